// File: src/evsa_pkg.sv
// Package for the echo voice slot assigner: word types, slot entry layout,
// command, outcome and register codes, and sizing constants. No dependencies.
`default_nettype none

package evsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = ($clog2(SLOT_COUNT + 1) > 9) ? $clog2(SLOT_COUNT + 1) : 9;

  localparam logic [SLOT_W-1:0] LAST_IDX   = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0] FIRST_IDX  = SLOT_W'(1);
  localparam logic [CNT_W-1:0]  SAT_ACTIVE = CNT_W'(511);

  localparam logic [16:0] BLEND_ONE = 17'h10000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_ASSIGN = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OUT_NONE  = 3'd0,
    OUT_MATCH = 3'd1,
    OUT_FREE  = 3'd2,
    OUT_STEAL = 3'd3,
    OUT_DROP  = 3'd4
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_RADIUS  = 3'd0,
    REG_STEAL_CEILING = 3'd1,
    REG_DECAY         = 3'd2,
    REG_SMOOTHING     = 3'd3,
    REG_SILENCE       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        goal_freq;
    logic [15:0]        goal_amp;
    logic [15:0]        echo_delay;
    logic [15:0]        pulse_width;
    logic [15:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [2:0] outcome;
    logic [8:0] active_slots;
  } out_word_t;

  typedef struct packed {
    logic               active;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        freq;
    logic [15:0]        goal_freq;
    logic [15:0]        amp;
    logic [15:0]        goal_amp;
    logic [15:0]        echo_delay;
    logic [15:0]        pulse_width;
  } slot_entry_t;

  localparam slot_entry_t ENTRY_RESET = '{pulse_width: 16'd3277, default: '0};

  // Slot entry as read from memory, one stage after the address.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } stage_t;

  // Registered products of the arithmetic stage.
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  idx;
    slot_entry_t        entry;
    logic signed [35:0] prod_a;
    logic signed [35:0] prod_b;
    logic signed [35:0] prod_c;
  } calc_t;

endpackage

`default_nettype wire

// File: src/evsa_calc.sv
// Arithmetic stage of the slot scan: three shared 18x18 multipliers, registered.
// Depends on evsa_pkg.
`default_nettype none

module evsa_calc import evsa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stage_t             stage_i,
  input  cmd_e               cmd_i,
  input  logic [16:0]        blend_i,
  input  logic [15:0]        decay_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  output calc_t              calc_o
);

  logic signed [16:0] dfreq, damp, dx, dy, dz;
  logic signed [17:0] a0, a1, b0, b1, c0, c1;
  logic               valid_q;
  logic [SLOT_W-1:0]  idx_q;
  slot_entry_t        entry_q;
  logic signed [35:0] prod_a_q, prod_b_q, prod_c_q;

  always_comb begin
    dfreq = $signed({1'b0, stage_i.entry.goal_freq}) - $signed({1'b0, stage_i.entry.freq});
    damp  = $signed({1'b0, stage_i.entry.goal_amp}) - $signed({1'b0, stage_i.entry.amp});
    dx    = $signed({stage_i.entry.pos_x[15], stage_i.entry.pos_x})
          - $signed({point_x_i[15], point_x_i});
    dy    = $signed({stage_i.entry.pos_y[15], stage_i.entry.pos_y})
          - $signed({point_y_i[15], point_y_i});
    dz    = $signed({stage_i.entry.pos_z[15], stage_i.entry.pos_z})
          - $signed({point_z_i[15], point_z_i});
    a0 = '0;
    a1 = '0;
    b0 = '0;
    b1 = '0;
    c0 = '0;
    c1 = '0;
    case (cmd_i)
      CMD_TICK: begin
        a0 = {dfreq[16], dfreq};
        a1 = {1'b0, blend_i};
        b0 = {damp[16], damp};
        b1 = {1'b0, blend_i};
      end
      CMD_FRAME: begin
        a0 = {2'b00, stage_i.entry.goal_amp};
        a1 = {2'b00, decay_i};
      end
      CMD_ASSIGN: begin
        a0 = {dx[16], dx};
        a1 = {dx[16], dx};
        b0 = {dy[16], dy};
        b1 = {dy[16], dy};
        c0 = {dz[16], dz};
        c1 = {dz[16], dz};
      end
      default: begin
        a0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= stage_i.idx;
    entry_q  <= stage_i.entry;
    prod_a_q <= a0 * a1;
    prod_b_q <= b0 * b1;
    prod_c_q <= c0 * c1;
  end

  assign calc_o = '{valid: valid_q, idx: idx_q, entry: entry_q,
                    prod_a: prod_a_q, prod_b: prod_b_q, prod_c: prod_c_q};

endmodule

`default_nettype wire

// File: src/echo_voice_slot_assigner.sv
// Top level of the echo voice slot assigner: slot memory, command sequencer,
// write-back stage and result register. Depends on evsa_pkg and evsa_calc.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o | in_word_i  (in_word_t)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (out_word_t)
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One command at a time. Tick and begin-frame sweep all SLOT_COUNT slots, one
// slot memory read and at most one write-back per cycle through a three-stage
// read / multiply / write pipeline: the result word is loaded into the output
// register after the sweep, and the next word is taken once it has been loaded.
// Assign sweeps slots 1 and up, then rereads and rewrites the chosen slot; a
// dropped point skips the reread and rewrite. The unused command answers
// without a sweep. Reset clears the per-slot written bits; an unwritten slot
// reads as its reset value (inactive), so there is no clearing pass.
// A stalled result holds in the output register; the next word is still
// accepted and the sweep waits only at its end for the register to free up.
`default_nettype none

module echo_voice_slot_assigner import evsa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_PICK  = 8'b0000_1000,
    S_LOAD  = 8'b0001_0000,
    S_STORE = 8'b0010_0000,
    S_REPLY = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_e;

  // Configuration registers.
  logic [31:0] radius_q;
  logic [15:0] ceiling_q, decay_q, silence_q;
  logic [7:0]  rate_q;

  // Sequencer.
  state_e            state_q, state_d;
  cmd_e              cmd_q;
  in_word_t          word_q;
  logic [16:0]       blend_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              in_accept;
  logic [23:0]       blend_prod;
  logic [16:0]       blend_full;

  // Slot memory and its per-entry written bits.
  slot_entry_t           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written_q;
  slot_entry_t           rdata_q;
  logic                  rvalid_q;
  logic                  rd_en, wr_en;
  logic [SLOT_W-1:0]     rd_addr, wr_idx;
  slot_entry_t           wr_data;
  slot_entry_t           rd_entry;

  // Pipeline.
  logic              v1_q;
  logic [SLOT_W-1:0] idx1_q;
  stage_t            stage1;
  calc_t             calc;

  // Running count of active slots.
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Assign trackers.
  logic [34:0]       best_q;
  logic [15:0]       low_q;
  logic              have_match_q, have_free_q, have_steal_q;
  logic [SLOT_W-1:0] match_idx_q, free_idx_q, steal_idx_q;
  logic [SLOT_W-1:0] chosen_q;
  outcome_e          outcome_q;

  // Write-back stage.
  logic              calc_active;
  logic [15:0]       new_freq, new_amp, new_goal;
  logic [34:0]       sq_dist;
  logic              deact;
  slot_entry_t       tick_entry, frame_entry, store_entry;

  // Result register.
  logic                out_valid_q;
  out_word_t           out_word_q;
  logic                out_free;
  logic [SLOT_W+7:0]   slot_ext;

  // ---------------------------------------------------------------------
  // Configuration port: plain writes, unknown indexes are dropped.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 32'd6554;
      ceiling_q <= 16'd4096;
      decay_q   <= 16'd62259;
      rate_q    <= 8'd5;
      silence_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MATCH_RADIUS:  radius_q  <= cfg_data_i;
        REG_STEAL_CEILING: ceiling_q <= cfg_data_i[15:0];
        REG_DECAY:         decay_q   <= cfg_data_i[15:0];
        REG_SMOOTHING:     rate_q    <= cfg_data_i[7:0];
        REG_SILENCE:       silence_q <= cfg_data_i[15:0];
        default:           radius_q  <= radius_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input handshake and blend factor: min(rate * dt, 1.0) in Q1.16.
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign blend_prod = 24'(rate_q) * 24'(in_word_i.time_step);
  assign blend_full = (blend_prod > 24'(BLEND_ONE)) ? BLEND_ONE : blend_prod[16:0];

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (cmd_e'(in_word_i.cmd) == CMD_NONE) begin
            state_d = S_REPLY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Wait until the last slot has left the write-back stage.
        if (!v1_q && !calc.valid) begin
          state_d = (cmd_q == CMD_ASSIGN) ? S_PICK : S_REPLY;
        end
      end
      S_PICK: begin
        state_d = (have_match_q || have_free_q || have_steal_q) ? S_LOAD : S_REPLY;
      end
      S_LOAD:  state_d = S_STORE;
      S_STORE: state_d = S_REPLY;
      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_NONE;
      rd_idx_q <= '0;
      v1_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == S_SCAN);
      if (in_accept) begin
        cmd_q    <= cmd_e'(in_word_i.cmd);
        // Slot 0 is reserved: assign sweeps from slot 1.
        rd_idx_q <= (cmd_e'(in_word_i.cmd) == CMD_ASSIGN) ? FIRST_IDX : '0;
      end else if (state_q == S_SCAN && rd_idx_q != LAST_IDX) begin
        rd_idx_q <= rd_idx_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= rd_idx_q;
    if (in_accept) begin
      word_q  <= in_word_i;
      blend_q <= blend_full;
    end
  end

  // ---------------------------------------------------------------------
  // Slot memory: one read and one write port, read data registered.
  // ---------------------------------------------------------------------
  assign rd_en   = (state_q == S_SCAN) || (state_q == S_LOAD);
  assign rd_addr = (state_q == S_LOAD) ? chosen_q : rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_q[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= written_q[rd_addr];
      end
    end
  end

  // An entry never written reads as its reset value.
  assign rd_entry = rvalid_q ? rdata_q : ENTRY_RESET;

  assign stage1 = '{valid: v1_q, idx: idx1_q, entry: rd_entry};

  evsa_calc u_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage1),
    .cmd_i     (cmd_q),
    .blend_i   (blend_q),
    .decay_i   (decay_q),
    .point_x_i (word_q.pos_x),
    .point_y_i (word_q.pos_y),
    .point_z_i (word_q.pos_z),
    .calc_o    (calc)
  );

  // ---------------------------------------------------------------------
  // Write-back stage.
  // ---------------------------------------------------------------------
  assign calc_active = calc.entry.active;

  // Blend: x + floor((target - x) * f / 2^16), exact against the weighted form.
  assign new_freq = calc.entry.freq + 16'(calc.prod_a >>> 16);
  assign new_amp  = calc.entry.amp + 16'(calc.prod_b >>> 16);
  assign new_goal = calc.prod_a[31:16];
  assign sq_dist  = 35'(calc.prod_a[33:0]) + 35'(calc.prod_b[33:0]) + 35'(calc.prod_c[33:0]);
  assign deact    = (cmd_q == CMD_TICK) && calc.valid && calc_active
                 && (new_amp < silence_q) && (calc.entry.goal_amp < silence_q);

  always_comb begin
    tick_entry        = calc.entry;
    tick_entry.freq   = new_freq;
    tick_entry.amp    = new_amp;
    // Retire the slot once it has gone silent.
    tick_entry.active = !deact;
    frame_entry          = calc.entry;
    frame_entry.goal_amp = new_goal;
    // Load the point; current frequency and amplitude carry over.
    store_entry             = rd_entry;
    store_entry.active      = 1'b1;
    store_entry.pos_x       = word_q.pos_x;
    store_entry.pos_y       = word_q.pos_y;
    store_entry.pos_z       = word_q.pos_z;
    store_entry.norm_x      = word_q.norm_x;
    store_entry.norm_y      = word_q.norm_y;
    store_entry.norm_z      = word_q.norm_z;
    store_entry.goal_freq   = word_q.goal_freq;
    store_entry.goal_amp    = word_q.goal_amp;
    store_entry.echo_delay  = word_q.echo_delay;
    store_entry.pulse_width = word_q.pulse_width;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = calc.idx;
    wr_data = tick_entry;
    if (state_q == S_STORE) begin
      wr_en   = 1'b1;
      wr_idx  = chosen_q;
      wr_data = store_entry;
    end else if (calc.valid && calc_active) begin
      case (cmd_q)
        CMD_TICK: begin
          wr_en   = 1'b1;
          wr_data = tick_entry;
        end
        CMD_FRAME: begin
          wr_en   = 1'b1;
          wr_data = frame_entry;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Running count: drop on a retired slot, advance when a free slot is loaded.
  always_comb begin
    cnt_d = cnt_q;
    if (deact) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (state_q == S_STORE && !rd_entry.active) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Assign trackers: nearest match, first free slot, quietest stealable slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_match_q <= 1'b0;
      have_free_q  <= 1'b0;
      have_steal_q <= 1'b0;
      chosen_q     <= '0;
      outcome_q    <= OUT_NONE;
    end else begin
      if (in_accept) begin
        have_match_q <= 1'b0;
        have_free_q  <= 1'b0;
        have_steal_q <= 1'b0;
        chosen_q     <= '0;
        outcome_q    <= OUT_NONE;
      end else if (calc.valid && cmd_q == CMD_ASSIGN) begin
        if (calc_active && sq_dist < best_q) begin
          have_match_q <= 1'b1;
        end
        if (!calc_active) begin
          have_free_q <= 1'b1;
        end
        if (calc.entry.amp < low_q) begin
          have_steal_q <= 1'b1;
        end
      end else if (state_q == S_PICK) begin
        if (have_match_q) begin
          chosen_q  <= match_idx_q;
          outcome_q <= OUT_MATCH;
        end else if (have_free_q) begin
          chosen_q  <= free_idx_q;
          outcome_q <= OUT_FREE;
        end else if (have_steal_q) begin
          chosen_q  <= steal_idx_q;
          outcome_q <= OUT_STEAL;
        end else begin
          outcome_q <= OUT_DROP;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      best_q <= 35'(radius_q);
      low_q  <= ceiling_q;
    end else if (calc.valid && cmd_q == CMD_ASSIGN) begin
      if (calc_active && sq_dist < best_q) begin
        best_q      <= sq_dist;
        match_idx_q <= calc.idx;
      end
      if (!calc_active && !have_free_q) begin
        free_idx_q <= calc.idx;
      end
      if (calc.entry.amp < low_q) begin
        low_q       <= calc.entry.amp;
        steal_idx_q <= calc.idx;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  assign slot_ext = {8'b0, chosen_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_REPLY && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_REPLY && out_free) begin
      out_word_q.slot         <= slot_ext[7:0];
      out_word_q.outcome      <= outcome_q;
      out_word_q.active_slots <= (cnt_q > SAT_ACTIVE) ? 9'd511 : cnt_q[8:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
`ifndef SYNTHESIS
  // The sweep never reads the entry being written back in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_idx != rd_addr))
    else $error("slot memory read and write hit the same entry");

  // Running count never exceeds the bank size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOT_COUNT))
    else $error("active count above bank size");

  // Pipeline is empty when the assign decision is made.
  a_pick_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> (!v1_q && !calc.valid))
    else $error("assign decision taken with slots still in flight");

  // A result without a chosen slot reports slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.outcome != OUT_MATCH && out_word_q.outcome != OUT_FREE
     && out_word_q.outcome != OUT_STEAL) |-> (out_word_q.slot == 8'd0))
    else $error("nonzero slot on a result without assignment");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking bench for echo_voice_slot_assigner: drives command words, models
// the slot bank in a scoreboard class and checks every slot report field by field.
// Depends on evsa_pkg and the echo_voice_slot_assigner RTL.

module testbench;
  import evsa_pkg::*;

  // Allow one sweep, the longest sender gap and a long receiver stall, many times over.
  localparam int IDLE_LIMIT = 16 * (SLOT_COUNT + 8);

  // Bank model and the queue of slot reports still owed by the block.
  class slot_bank_scoreboard;
    bit          live[SLOT_COUNT];
    slot_entry_t bank[SLOT_COUNT];
    logic [31:0] radius_sq;
    logic [15:0] ceiling;
    logic [15:0] decay;
    logic [7:0]  rate;
    logic [15:0] silence;
    out_word_t   due_reports[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        live[i] = 1'b0;
        bank[i] = ENTRY_RESET;
      end
      radius_sq = 32'd6554;
      ceiling   = 16'd4096;
      decay     = 16'd62259;
      rate      = 8'd5;
      silence   = 16'd1;
      errors    = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [31:0] v);
      case (r)
        REG_MATCH_RADIUS:  radius_sq = v;
        REG_STEAL_CEILING: ceiling = v[15:0];
        REG_DECAY:         decay = v[15:0];
        REG_SMOOTHING:     rate = v[7:0];
        REG_SILENCE:       silence = v[15:0];
        default: ;
      endcase
    endfunction

    // Move cur toward goal by f/65536, rounding down.
    function logic [15:0] mix(logic [15:0] cur, logic [15:0] goal, logic [16:0] f);
      longint unsigned acc;
      acc = longint'(cur) * (65536 - f) + longint'(goal) * f;
      return 16'(acc >> 16);
    endfunction

    function longint sq_gap(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // Apply one accepted command word to the bank and queue the report it owes.
    function void note_command(in_word_t w);
      out_word_t   r;
      int unsigned pick;
      int unsigned quietest;
      int unsigned n;
      outcome_e    verdict;
      longint      nearest;
      longint      span;
      logic [23:0] prod_f;
      logic [16:0] f;
      logic [31:0] prod;

      pick    = 0;
      verdict = OUT_NONE;
      case (cmd_e'(w.cmd))
        CMD_TICK: begin
          prod_f = 24'(rate) * 24'(w.time_step);
          f = (prod_f > BLEND_ONE) ? BLEND_ONE : prod_f[16:0];
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (live[i]) begin
              bank[i].freq = mix(bank[i].freq, bank[i].goal_freq, f);
              bank[i].amp  = mix(bank[i].amp, bank[i].goal_amp, f);
              if (bank[i].amp < silence && bank[i].goal_amp < silence) live[i] = 1'b0;
            end
          end
        end
        CMD_FRAME: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (live[i]) begin
              prod = {16'b0, bank[i].goal_amp} * {16'b0, decay};
              bank[i].goal_amp = prod[31:16];
            end
          end
        end
        CMD_ASSIGN: begin
          // Nearest active slot strictly inside the radius; lowest index on ties.
          nearest = longint'(radius_sq);
          for (int i = 1; i < SLOT_COUNT; i++) begin
            if (live[i]) begin
              span = sq_gap(bank[i].pos_x, w.pos_x) + sq_gap(bank[i].pos_y, w.pos_y)
                   + sq_gap(bank[i].pos_z, w.pos_z);
              if (span < nearest) begin
                nearest = span;
                pick    = i;
                verdict = OUT_MATCH;
              end
            end
          end
          if (pick == 0) begin
            for (int i = 1; i < SLOT_COUNT; i++) begin
              if (!live[i]) begin
                pick    = i;
                verdict = OUT_FREE;
                break;
              end
            end
          end
          if (pick == 0) begin
            quietest = ceiling;
            for (int i = 1; i < SLOT_COUNT; i++) begin
              if (bank[i].amp < quietest) begin
                quietest = bank[i].amp;
                pick     = i;
                verdict  = OUT_STEAL;
              end
            end
          end
          if (pick == 0) begin
            verdict = OUT_DROP;
          end else begin
            live[pick]              = 1'b1;
            bank[pick].pos_x        = w.pos_x;
            bank[pick].pos_y        = w.pos_y;
            bank[pick].pos_z        = w.pos_z;
            bank[pick].norm_x       = w.norm_x;
            bank[pick].norm_y       = w.norm_y;
            bank[pick].norm_z       = w.norm_z;
            bank[pick].goal_freq    = w.goal_freq;
            bank[pick].goal_amp     = w.goal_amp;
            bank[pick].echo_delay   = w.echo_delay;
            bank[pick].pulse_width  = w.pulse_width;
          end
        end
        default: ;
      endcase

      n = 0;
      for (int i = 0; i < SLOT_COUNT; i++) n += live[i];
      r.slot         = pick[7:0];
      r.outcome      = verdict;
      r.active_slots = (n > 511) ? 9'd511 : n[8:0];
      due_reports = {due_reports, r};
    endfunction

    function void check_report(out_word_t got);
      out_word_t want;
      if (due_reports.size() == 0) begin
        $error("slot report with none due: slot %0d outcome %0d active %0d",
               got.slot, got.outcome, got.active_slots);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
        errors++;
      end
      if (got.active_slots !== want.active_slots) begin
        $error("active_slots: expected %0d, got %0d", want.active_slots, got.active_slots);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_word_t             out_word_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  slot_bank_scoreboard sb = new();

  // Cluster centers: points jittered around them land within 120 of each other per axis.
  logic signed [15:0] pool_x[16];
  logic signed [15:0] pool_y[16];
  logic signed [15:0] pool_z[16];

  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  echo_voice_slot_assigner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: switch between never stalling, coin-flip stalls and mostly stalled,
  // each for a random stretch of cycles.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 1500);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor both channels on the pre-edge values; feed the scoreboard and
  // run the watchdog on cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
      sb.note_command(in_word_i);
      idle_cycles = 0;
    end else if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_report(out_word_o);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** echo_voice_slot_assigner: FAILED **");
      $finish;
    end
  end

  // Random fill for every field; callers override what matters.
  function automatic in_word_t noise_word();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return in_word_t'(raw[$bits(in_word_t)-1:0]);
  endfunction

  function automatic in_word_t point_word(logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z, logic [15:0] amp);
    in_word_t w;
    w          = noise_word();
    w.cmd      = CMD_ASSIGN;
    w.pos_x    = x;
    w.pos_y    = y;
    w.pos_z    = z;
    w.goal_amp = amp;
    return w;
  endfunction

  function automatic in_word_t tick_word(logic [15:0] ts);
    in_word_t w;
    w           = noise_word();
    w.cmd       = CMD_TICK;
    w.time_step = ts;
    return w;
  endfunction

  function automatic in_word_t frame_word();
    in_word_t w;
    w     = noise_word();
    w.cmd = CMD_FRAME;
    return w;
  endfunction

  function automatic logic signed [15:0] extreme_coord();
    case ($urandom_range(0, 2))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'sh0000;
    endcase
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] base);
    return base + $signed(16'($urandom_range(0, 120))) - 16'sd60;
  endfunction

  // Assigns for assign_pct percent, near cluster centers, at extreme coordinates or
  // anywhere; the rest ticks and frames, with an occasional unused command as noise.
  function automatic in_word_t random_word(int assign_pct);
    in_word_t           w;
    int                 roll;
    int                 k;
    logic signed [15:0] x, y, z;
    logic [15:0]        amp;
    logic [15:0]        ts;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      w     = noise_word();
      w.cmd = CMD_NONE;
    end else if (roll < 2 + assign_pct) begin
      case ($urandom_range(0, 3))
        0: begin
          x = 16'($urandom);
          y = 16'($urandom);
          z = 16'($urandom);
        end
        3: begin
          x = extreme_coord();
          y = extreme_coord();
          z = extreme_coord();
        end
        default: begin
          k = $urandom_range(0, 15);
          x = nudge(pool_x[k]);
          y = nudge(pool_y[k]);
          z = nudge(pool_z[k]);
        end
      endcase
      case ($urandom_range(0, 3))
        0:       amp = 16'($urandom_range(0, 16));
        1:       amp = 16'hFFFF;
        default: amp = 16'($urandom);
      endcase
      w = point_word(x, y, z, amp);
    end else if (roll < 2 + assign_pct + (98 - assign_pct) / 2) begin
      case ($urandom_range(0, 3))
        0:       ts = 16'h0000;
        1:       ts = 16'($urandom_range(0, 400));
        2:       ts = 16'hFFFF;
        default: ts = 16'($urandom);
      endcase
      w = tick_word(ts);
    end else begin
      w = frame_word();
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then keep the burst going or
  // drop valid for a random gap.
  task automatic send_word(in_word_t w);
    int gap;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = $urandom_range(1, 4);
        5, 6, 7:       gap = $urandom_range(5, 40);
        default:       gap = $urandom_range(41, 300);
      endcase
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_random(int count, int assign_pct);
    in_word_t w;
    int       done;
    done = 0;
    while (done < count) begin
      w = random_word(assign_pct);
      send_word(w);
      if (w.cmd != CMD_NONE) done++;
    end
  endtask

  // Drop valid and wait until every owed report has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v;
    sb.set_reg(r, v);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [31:0] radius, logic [15:0] ceil_v, logic [15:0] decay_v,
                                logic [7:0] rate_v, logic [15:0] silence_v);
    write_reg(REG_MATCH_RADIUS, radius);
    write_reg(REG_STEAL_CEILING, ceil_v);
    write_reg(REG_DECAY, decay_v);
    write_reg(REG_SMOOTHING, rate_v);
    write_reg(REG_SILENCE, silence_v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    in_word_t    w;
    logic [31:0] radius;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_MATCH_RADIUS;
    cfg_data_i  <= '0;
    for (int k = 0; k < 16; k++) begin
      pool_x[k] = 16'($urandom);
      pool_y[k] = 16'($urandom);
      pool_z[k] = 16'($urandom);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset register values.
    send_word(tick_word(16'h0000));                      // tick on an empty bank
    send_word(frame_word());                             // frame on an empty bank
    w = '1;
    send_word(w);                                        // unused command, every bit set
    send_word(point_word(16'sd0, 16'sd0, 16'sd0, 16'h1000));   // first free slot
    send_word(point_word(16'sd0, 16'sd0, 16'sd0, 16'h0800));   // zero distance match
    send_word(point_word(16'sd100, 16'sd0, 16'sd0, 16'h0400)); // just outside the radius
    send_word(point_word(16'sd50, 16'sd0, 16'sd0, 16'h0200));  // equal distance tie
    w = '1;
    w.cmd = CMD_ASSIGN;
    {w.pos_x, w.pos_y, w.pos_z, w.norm_x, w.norm_y, w.norm_z} = {6{16'h7FFF}};
    send_word(w);                                        // all fields at their top
    w = '0;
    w.cmd = CMD_ASSIGN;
    {w.pos_x, w.pos_y, w.pos_z, w.norm_x, w.norm_y, w.norm_z} = {6{16'h8000}};
    send_word(w);                                        // all fields at their bottom
    send_word(point_word(16'sd177, 16'sd25, 16'sd0, 16'h0100)); // distance equal to radius
    send_word(point_word(16'sd176, 16'sd25, 16'sd0, 16'h0300)); // inside two radii
    send_word(frame_word());
    send_word(tick_word(16'h0000));                      // zero blend factor
    send_word(tick_word(16'hFFFF));                      // blend factor saturates at one
    send_word(tick_word(16'd13107));                     // blend factor just below one
    send_word(point_word(16'sd1000, 16'sd1000, 16'sd1000, 16'h0000)); // silent point
    send_word(tick_word(16'd100));                       // retire silent slots
    send_word(point_word(16'sd2000, 16'sd2000, 16'sd2000, 16'h2000)); // reuse a retired slot
    run_random(150, 70);
    drain();

    // No matching, no stealing, never silent: fill the bank and drop the overflow.
    apply_settings(32'd0, 16'd0, 16'hFFFF, 8'hFF, 16'd0);
    run_random(200, 95);
    drain();

    // Full bank with every quiet slot open to stealing.
    apply_settings(32'd0, 16'hFFFF, 16'd0, 8'd1, 16'd0);
    run_random(150, 80);
    drain();

    // Match radius at its maximum, freeze blending, retire nearly everything on a tick.
    apply_settings(32'hFFFF_FFFF, 16'h0800, 16'h8000, 8'd0, 16'hFFFF);
    run_random(80, 50);
    drain();

    // Back to reset values, then random settings.
    apply_settings(32'd6554, 16'd4096, 16'd62259, 8'd5, 16'd1);
    run_random(100, 70);
    drain();
    for (int p = 0; p < 2; p++) begin
      case ($urandom_range(0, 2))
        0:       radius = $urandom_range(0, 20000);
        1:       radius = $urandom_range(0, 2000000);
        default: radius = $urandom;
      endcase
      apply_settings(radius, 16'($urandom), 16'($urandom), 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)));
      run_random(100, 70);
      drain();
    end

    // Let any stray report surface before the verdict.
    repeat (SLOT_COUNT + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** echo_voice_slot_assigner: PASSED **");
    end else begin
      $display("** echo_voice_slot_assigner: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
src/evsa_pkg.sv
src/evsa_calc.sv
src/echo_voice_slot_assigner.sv
sim/testbench.sv
